// ===== rtl/core/lcd_line_mode_timing_defines.svh =====
// lcd_line_mode_timing_defines.svh: assertion macros for the lcd line and mode timing block
// expects signals clk and arst_n in the scope where a macro is used
`ifndef LCD_LINE_MODE_TIMING_DEFINES_SVH
`define LCD_LINE_MODE_TIMING_DEFINES_SVH

// same-cycle implication, checked outside reset
`define LLMT_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("lcd timing check failed");

// next-cycle implication, checked outside reset
`define LLMT_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("lcd timing check failed");

`endif

// ===== rtl/core/llmt_pkg.sv =====
// llmt_pkg.sv: constants for the lcd line and mode timing block
// no dependencies
`default_nettype none

package llmt_pkg;

	localparam int CNT_W  = 17;
	localparam int LINE_W = 8;
	localparam int MODE_W = 2;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 8;
	localparam int EN_W = 4;

	localparam logic [CNT_W-1:0] FRAME_CYCLES = 17'd70224;
	localparam logic [CNT_W-1:0] LINE_CYCLES  = 17'd456;
	localparam logic [CNT_W-1:0] DRAW_START   = 17'd80;
	localparam logic [CNT_W-1:0] HBLANK_START = 17'd252;
	localparam logic [LINE_W-1:0] VISIBLE_LINES = 8'd144;
	localparam logic [LINE_W-1:0] TOTAL_LINES   = 8'd154;

	// mode codes
	localparam logic [MODE_W-1:0] MODE_HBLANK = 2'd0;
	localparam logic [MODE_W-1:0] MODE_VBLANK = 2'd1;
	localparam logic [MODE_W-1:0] MODE_OAM    = 2'd2;
	localparam logic [MODE_W-1:0] MODE_DRAW   = 2'd3;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_LINE_COMPARE = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_STAT_ENABLES = 1'd1;

	// interrupt enable bit positions
	localparam int EN_HBLANK  = 0;
	localparam int EN_VBLANK  = 1;
	localparam int EN_OAM     = 2;
	localparam int EN_COMPARE = 3;

endpackage

`default_nettype wire

// ===== rtl/core/lcd_line_mode_timing.sv =====
// lcd_line_mode_timing.sv: display line counter, mode sequencer and interrupt requests
// depends on llmt_pkg and lcd_line_mode_timing_defines.svh
//
// usage:
//  - input channel (in_valid / in_stall) carries one word per tick: elapsed_cycles,
//    lcd_on and clear_frame; a word is taken when in_valid is high and in_stall low
//  - output channel (out_valid / out_stall) returns exactly one word per input word:
//    mode, line, line_match, the pulses vblank_irq, status_irq, render_strobe,
//    render_row and the sticky frame_ready flag
//  - config port: cfg_we writes cfg_data into register cfg_index (0 line compare,
//    1 status interrupt enables); write only while no word is in flight
//  - path: an accepted word is captured in the input register, and its result is then
//    written into the result register, from which it is taken
//  - throughput: one word per cycle while out_stall is low; the counter, line and
//    mode update combinationally around state registers; words may come back to back
//  - stall: while out_stall holds a full result register, the result stays put and
//    one more word can wait in the input register; in_stall rises only when both
//    registers are occupied and the output is stalled
//  - reset: counter, line, mode, compare and frame flags and both config registers
//    clear to zero, both channels empty
`default_nettype none

`include "lcd_line_mode_timing_defines.svh"

module lcd_line_mode_timing
	import llmt_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	// config write port
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	// input channel
	input  wire logic                  in_valid,
	output      logic                  in_stall,
	input  wire logic [7:0]            elapsed_cycles,
	input  wire logic                  lcd_on,
	input  wire logic                  clear_frame,
	// output channel
	output      logic                  out_valid,
	input  wire logic                  out_stall,
	output      logic [MODE_W-1:0]     mode,
	output      logic [LINE_W-1:0]     line,
	output      logic                  line_match,
	output      logic                  vblank_irq,
	output      logic                  status_irq,
	output      logic                  frame_ready,
	output      logic                  render_strobe,
	output      logic [LINE_W-1:0]     render_row
);

	// config registers
	logic [LINE_W-1:0] line_compare_q;
	logic [EN_W-1:0]   stat_en_q;

	// input register
	logic       valid_s1;
	logic [7:0] elapsed_s1;
	logic       lcd_on_s1;
	logic       clear_s1;

	// timing state
	logic [CNT_W-1:0]  cnt_q;
	logic [LINE_W-1:0] line_q;
	logic [MODE_W-1:0] mode_q;
	logic              match_q;
	logic              frame_q;

	// next-state and result logic
	logic [CNT_W-1:0]  sum;
	logic [CNT_W-1:0]  cnt_n;
	logic [LINE_W-1:0] line_n;
	logic [LINE_W-1:0] adv_line;
	logic [MODE_W-1:0] mode_n;
	logic [MODE_W-1:0] want_mode;
	logic              want_valid;
	logic              match_n;
	logic              frame_n;
	logic              vblank_n;
	logic              stat_n;
	logic              strobe_n;
	logic [LINE_W-1:0] row_n;
	logic              mode_stat;

	logic advance;  // result register can take a new word
	logic take;     // word in input register is processed this cycle

	assign advance  = !out_valid || !out_stall;
	assign take     = valid_s1 && advance;
	assign in_stall = valid_s1 && !advance;

	// config writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_compare_q <= '0;
			stat_en_q      <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_LINE_COMPARE: line_compare_q <= cfg_data;
				REG_STAT_ENABLES: stat_en_q      <= cfg_data[EN_W-1:0];
				default: ;
			endcase
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			elapsed_s1 <= elapsed_cycles;
			lcd_on_s1  <= lcd_on;
			clear_s1   <= clear_frame;
		end
	end

	// one step of line and mode timing
	always_comb begin
		sum        = cnt_q + {{(CNT_W-8){1'b0}}, elapsed_s1};
		cnt_n      = sum;
		line_n     = line_q;
		adv_line   = line_q + 8'd1;
		want_mode  = MODE_HBLANK;
		want_valid = 1'b0;
		match_n    = match_q;
		frame_n    = clear_s1 ? 1'b0 : frame_q;
		vblank_n   = 1'b0;
		stat_n     = 1'b0;
		strobe_n   = 1'b0;
		row_n      = '0;

		if (!lcd_on_s1) begin
			// frame-only counting, line and mode held at zero
			if (sum >= FRAME_CYCLES) begin
				cnt_n    = sum - FRAME_CYCLES;
				vblank_n = 1'b1;
				frame_n  = 1'b1;
			end
			line_n     = '0;
			want_mode  = MODE_HBLANK;
			want_valid = 1'b1;
		end else begin
			if (line_q < VISIBLE_LINES) begin
				// mode stays as is on the step that ends the line
				if (sum < DRAW_START) begin
					want_mode  = MODE_OAM;
					want_valid = 1'b1;
				end else if (sum < HBLANK_START) begin
					want_mode  = MODE_DRAW;
					want_valid = 1'b1;
				end else if (sum < LINE_CYCLES) begin
					want_mode  = MODE_HBLANK;
					want_valid = 1'b1;
				end
			end else begin
				want_mode  = MODE_VBLANK;
				want_valid = 1'b1;
			end

			if (sum >= LINE_CYCLES) begin
				cnt_n = sum - LINE_CYCLES;
				if (line_q < VISIBLE_LINES) begin
					strobe_n = 1'b1;
					row_n    = line_q;
				end
				// compare before the wrap, so line 154 is what gets compared
				if (adv_line == line_compare_q) begin
					match_n = 1'b1;
					stat_n  = stat_en_q[EN_COMPARE];
				end else begin
					match_n = 1'b0;
				end
				if (adv_line == TOTAL_LINES) begin
					line_n  = '0;
					frame_n = 1'b1;
				end else begin
					line_n = adv_line;
				end
				if (adv_line == VISIBLE_LINES) begin
					vblank_n = 1'b1;
				end
			end
		end

		// status request on an actual change into hblank, vblank or oam scan
		mode_stat = 1'b0;
		if (want_valid && want_mode != mode_q) begin
			case (want_mode)
				MODE_HBLANK: mode_stat = stat_en_q[EN_HBLANK];
				MODE_VBLANK: mode_stat = stat_en_q[EN_VBLANK];
				MODE_OAM:    mode_stat = stat_en_q[EN_OAM];
				default:     mode_stat = 1'b0;
			endcase
		end
		mode_n = want_valid ? want_mode : mode_q;
		stat_n = stat_n || mode_stat;
	end

	// timing state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q   <= '0;
			line_q  <= '0;
			mode_q  <= MODE_HBLANK;
			match_q <= 1'b0;
			frame_q <= 1'b0;
		end else if (take) begin
			cnt_q   <= cnt_n;
			line_q  <= line_n;
			mode_q  <= mode_n;
			match_q <= match_n;
			frame_q <= frame_n;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (advance) begin
			out_valid <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			mode          <= mode_n;
			line          <= line_n;
			line_match    <= match_n;
			vblank_irq    <= vblank_n;
			status_irq    <= stat_n;
			frame_ready   <= frame_n;
			render_strobe <= strobe_n;
			render_row    <= row_n;
		end
	end

	// checks
	`LLMT_ASSERT_NOW(a_stall_only_when_full, in_stall, out_valid && out_stall)
	`LLMT_ASSERT_NOW(a_line_in_range, out_valid, line < TOTAL_LINES)
	`LLMT_ASSERT_NOW(a_strobe_row_follows, out_valid && render_strobe,
		(render_row + 8'd1) == line)
	`LLMT_ASSERT_NOW(a_row_zero_idle, out_valid && !render_strobe, render_row == 8'd0)
	`LLMT_ASSERT_NOW(a_vblank_line, out_valid && vblank_irq,
		line == VISIBLE_LINES || line == 8'd0)
	`LLMT_ASSERT_NEXT(a_take_fills_output, take, out_valid)

endmodule

`default_nettype wire
